// ===== hdl/frdq_pkg.sv =====
// ----------------------------------------------------------------------------
// frdq_pkg
// Shared codes, field widths and controller/datapath interface types for the
// floor request dedup queue.
// ----------------------------------------------------------------------------
package frdq_pkg;

  localparam int FUNC_W  = 1;
  localparam int FLOOR_W = 8;
  localparam int CODE_W  = 8;
  localparam int OUT_W   = 4;

  localparam logic [FUNC_W-1:0] FUNC_REQ  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_CTRL = 1'b1;

  localparam logic [CODE_W-1:0] CODE_READY = 8'd3;
  localparam logic [CODE_W-1:0] CODE_BUSY  = 8'd4;

  typedef struct packed {
    logic capture;
    logic eval;
    logic pop;
  } frdq_cmd_t;

  typedef struct packed {
    logic pop_go;
  } frdq_stat_t;

endpackage

// ===== hdl/floor_request_dedup_queue_core.sv =====
// ----------------------------------------------------------------------------
// floor_request_dedup_queue_core
// Elevator call panel queue: deduplicated floor FIFO with dispatch gated by
// the last controller code.
// On a dispatch, an accepted transaction steps through the eval, read and pop
// states to out_valid; a transaction that dispatches nothing retires from eval.
// One transaction at a time: the sequencer accepts no new one until the last
// retires, and a held output stalls it; the read of the queue store is registered.
// Reset: queue empty, pending mask clear, stored code ready; store unset.
// ----------------------------------------------------------------------------
module floor_request_dedup_queue_core #(
  parameter int NUM_FLOORS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [frdq_pkg::FUNC_W-1:0]   func,
  input  logic [frdq_pkg::FLOOR_W-1:0]  floor,
  input  logic [frdq_pkg::CODE_W-1:0]   ctrl_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [frdq_pkg::OUT_W-1:0]    floor_out
);

  frdq_pkg::frdq_cmd_t  cmd;
  frdq_pkg::frdq_stat_t stat;

  frdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  frdq_datapath #(
    .NUM_FLOORS (NUM_FLOORS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .func      (func),
    .floor     (floor),
    .ctrl_code (ctrl_code),
    .floor_out (floor_out)
  );

endmodule

// ===== hdl/frdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// frdq_ctrl
// Sequencer: capture a transaction, evaluate it, read the queue head and
// hold the dispatched floor until taken.
// ----------------------------------------------------------------------------
module frdq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  frdq_pkg::frdq_stat_t stat,
  output frdq_pkg::frdq_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.eval    = 1'b0;
    cmd.pop     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.pop_go ? S_READ : S_IDLE;
      end
      S_READ: begin
        state_next = S_POP;
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

// ===== hdl/frdq_datapath.sv =====
// ----------------------------------------------------------------------------
// frdq_datapath
// Input register, pending mask, circular queue store with head/count,
// stored controller code and output register.
// ----------------------------------------------------------------------------
module frdq_datapath #(
  parameter int NUM_FLOORS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  frdq_pkg::frdq_cmd_t                 cmd,
  output frdq_pkg::frdq_stat_t                stat,
  input  logic [frdq_pkg::FUNC_W-1:0]         func,
  input  logic [frdq_pkg::FLOOR_W-1:0]        floor,
  input  logic [frdq_pkg::CODE_W-1:0]         ctrl_code,
  output logic [frdq_pkg::OUT_W-1:0]          floor_out
);

  localparam int FW = $clog2(NUM_FLOORS + 1);
  localparam int IW = $clog2(NUM_FLOORS);
  localparam int CW = $clog2(NUM_FLOORS + 1);
  localparam logic [frdq_pkg::FLOOR_W-1:0] MAX_FLOOR = frdq_pkg::FLOOR_W'(NUM_FLOORS);
  localparam logic [IW:0] DEPTH = (IW+1)'(NUM_FLOORS);
  localparam logic [IW-1:0] LAST = IW'(NUM_FLOORS - 1);

  logic [frdq_pkg::FUNC_W-1:0]  func_r;
  logic [frdq_pkg::FLOOR_W-1:0] floor_r;
  logic [frdq_pkg::CODE_W-1:0]  code_r;

  logic [NUM_FLOORS-1:0] pending;
  logic [IW-1:0]         head;
  logic [CW-1:0]         count;
  logic [frdq_pkg::CODE_W-1:0] mode_code;

  logic [FW-1:0] mem [NUM_FLOORS];
  logic [FW-1:0] rd_data;

  logic          in_range;
  logic [IW-1:0] req_idx;
  logic [IW-1:0] pop_idx;
  logic          do_push;
  logic [IW:0]   tail_sum;
  logic [IW-1:0] tail;
  logic [FW+frdq_pkg::OUT_W-1:0] rd_ext;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= func;
      floor_r <= floor;
      code_r  <= ctrl_code;
    end
  end

  assign in_range = (floor_r != '0) && (floor_r <= MAX_FLOOR);
  assign req_idx  = IW'(floor_r - 1'b1);
  assign pop_idx  = IW'(rd_data - 1'b1);
  assign do_push  = (func_r == frdq_pkg::FUNC_REQ) && in_range && !pending[req_idx];

  assign tail_sum = {1'b0, head} + (IW+1)'(count);
  assign tail     = (tail_sum >= DEPTH) ? IW'(tail_sum - DEPTH) : tail_sum[IW-1:0];

  always_comb begin
    if (func_r == frdq_pkg::FUNC_REQ) begin
      stat.pop_go = in_range && (mode_code != frdq_pkg::CODE_BUSY) &&
                    ((count != '0) || do_push);
    end else begin
      stat.pop_go = (code_r == frdq_pkg::CODE_READY) && (count != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && do_push) begin
      mem[tail] <= floor_r[FW-1:0];
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      head      <= '0;
      count     <= '0;
      mode_code <= frdq_pkg::CODE_READY;
    end else if (cmd.eval) begin
      if (func_r == frdq_pkg::FUNC_CTRL) begin
        mode_code <= code_r;
      end
      if (do_push) begin
        pending[req_idx] <= 1'b1;
        count            <= count + 1'b1;
      end
    end else if (cmd.pop) begin
      pending[pop_idx] <= 1'b0;
      head             <= (head == LAST) ? '0 : head + 1'b1;
      count            <= count - 1'b1;
    end
  end

  assign rd_ext = {{frdq_pkg::OUT_W{1'b0}}, rd_data};

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      floor_out <= rd_ext[frdq_pkg::OUT_W-1:0];
    end
  end

endmodule
